### rtl/assert_macros.svh
// Assertion helpers for the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define SFH_ASSERT_NOW(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("slot allocator check failed");

// Consequent checked in the cycle after the antecedent.
`define SFH_ASSERT_NEXT(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("slot allocator check failed");

`endif

### rtl/sfh_pkg.sv
package sfh_pkg;

	// Table size and derived widths.
	localparam int SLOT_COUNT = 1024;
	localparam int WORD_BITS  = 32;
	localparam int OFF_W      = $clog2(WORD_BITS);
	localparam int WORDS      = (SLOT_COUNT + WORD_BITS - 1) / WORD_BITS;
	localparam int WIDX_W     = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int ADDR_W     = WIDX_W + OFF_W;
	localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

	// Beat field widths.
	localparam int SLOT_W   = 10;
	localparam int SPAWN_W  = 32;
	localparam int LIVE_W   = 11;
	localparam int TOP_W    = 11;
	localparam int STATUS_W = 2;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_BAD_FREE = 2'd2
	} status_t;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef logic [WORD_BITS-1:0] word_t;

endpackage

### rtl/sfh_req_if.sv
interface sfh_req_if import sfh_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              operation;
	logic [SLOT_W-1:0] slot_index;

	modport source (output valid, operation, slot_index, input ready);
	modport sink   (input valid, operation, slot_index, output ready);
endinterface

### rtl/sfh_rsp_if.sv
interface sfh_rsp_if import sfh_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [STATUS_W-1:0]        status;
	logic [SLOT_W-1:0]          granted_slot;
	logic [SPAWN_W-1:0]         spawn_number;
	logic [LIVE_W-1:0]          live_count;
	logic signed [TOP_W-1:0]    highest_used;

	modport source (output valid, status, granted_slot, spawn_number, live_count,
		highest_used, input ready);
	modport sink   (input valid, status, granted_slot, spawn_number, live_count,
		highest_used, output ready);
endinterface

### rtl/slot_allocator_first_free_hint_core.sv
// Slot allocator with a first-free hint.
// req channel: operation (0 allocate, 1 free) and slot_index (used by free only).
// rsp channel: one beat per request with status, granted_slot, spawn_number,
//   live_count and highest_used (-1 when the table is empty).
// Occupancy lives in a 32-bit-wide synchronous memory, one word per 32 slots.
// One request is worked at a time. An allocate reads one word per cycle,
// starting at the word that holds the hint; a free reads the slot's word and,
// when the highest-used slot is freed, walks down one word per cycle.
// A request goes from idle through its scan states (alloc, or free then down)
// to emit, which loads the output register. A full table whose hint is already
// saturated, or an out-of-range free, goes from idle straight to emit.
// A new req beat is taken only once the current one is worked.
// req.ready is high only while no request is in flight; a finished rsp beat may
// sit in the output register while the next request is taken and worked.
// If the receiver stalls, the rsp beat holds and the following result waits
// until the output register frees.
// Reset: the table reads empty (per-word valid flags clear at once, no sweep),
// hint 0, highest used -1, live count 0, spawn counter 0.
module slot_allocator_first_free_hint_core import sfh_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	sfh_req_if.sink    req,
	sfh_rsp_if.source  rsp
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ALLOC,
		S_FREE,
		S_DOWN,
		S_EMIT
	} state_t;

	localparam logic [WIDX_W-1:0] LAST_WORD = WIDX_W'(WORDS - 1);
	localparam logic [WIDX_W-1:0] FIRST_WORD = '0;

	// Lowest set bit of a word.
	function automatic logic [OFF_W-1:0] lowest_set(word_t w);
		logic [OFF_W-1:0] idx;
		idx = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (w[i]) idx = OFF_W'(i);
		end
		return idx;
	endfunction

	// Highest set bit of a word.
	function automatic logic [OFF_W-1:0] highest_set(word_t w);
		logic [OFF_W-1:0] idx;
		idx = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (w[i]) idx = OFF_W'(i);
		end
		return idx;
	endfunction

	// Bits of a word that lie past the end of the table.
	function automatic word_t tail_mask(logic [WIDX_W-1:0] widx);
		word_t m;
		m = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (int'(widx) * WORD_BITS + i >= SLOT_COUNT) m[i] = 1'b1;
		end
		return m;
	endfunction

	// Occupancy memory and per-word valid flags
	word_t              mem [WORDS];
	logic [WORDS-1:0]   word_vld_q;
	word_t              rd_data_q;
	logic               rd_ok_q;

	logic               rd_en;
	logic [WIDX_W-1:0]  rd_addr;
	logic               wr_en;
	logic [WIDX_W-1:0]  wr_addr;
	word_t              wr_data;

	// Control and allocator state
	state_t                   state_q;
	logic [ADDR_W-1:0]        slot_q;
	logic [WIDX_W-1:0]        widx_q;
	logic [OFF_W-1:0]         off_q;
	logic [CNT_W-1:0]         hint_q;
	logic signed [ADDR_W:0]   top_q;
	logic [CNT_W-1:0]         live_q;
	logic [SPAWN_W-1:0]       spawn_q;

	// Result of the request in flight
	status_t                  res_status_q;
	logic [ADDR_W-1:0]        res_slot_q;
	logic [SPAWN_W-1:0]       res_spawn_q;

	// Output register
	logic                     out_valid_q;
	status_t                  out_status_q;
	logic [ADDR_W-1:0]        out_slot_q;
	logic [SPAWN_W-1:0]       out_spawn_q;
	logic [CNT_W-1:0]         out_live_q;
	logic signed [ADDR_W:0]   out_top_q;

	// Combinational helpers
	logic               accept;
	logic [ADDR_W-1:0]  in_slot;
	logic               in_range;
	logic               hint_full;
	logic [WIDX_W-1:0]  hint_widx;
	word_t              rd_word;
	word_t              alloc_free;
	logic               alloc_hit;
	logic [OFF_W-1:0]   alloc_pos;
	logic [ADDR_W-1:0]  alloc_slot;
	logic               free_bit;
	word_t              cleared;
	word_t              down_src;
	logic               down_hit;
	logic [OFF_W-1:0]   down_pos;
	logic               frees_top;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && (state_q == S_IDLE);
	assign in_slot   = ADDR_W'(req.slot_index);
	assign in_range  = int'(req.slot_index) < SLOT_COUNT;
	assign hint_full = hint_q >= CNT_W'(SLOT_COUNT);
	assign hint_widx = hint_q[OFF_W +: WIDX_W];

	// A word never written reads as empty.
	assign rd_word = rd_ok_q ? rd_data_q : '0;

	// Upward scan: treat bits below the start offset and past the table as taken.
	always_comb begin
		alloc_free = ~(rd_word | ((word_t'(1) << off_q) - word_t'(1)) | tail_mask(widx_q));
		alloc_hit  = |alloc_free;
		alloc_pos  = lowest_set(alloc_free);
		alloc_slot = {widx_q, alloc_pos};
	end

	// Free check and downward scan.
	always_comb begin
		free_bit  = rd_word[slot_q[OFF_W-1:0]];
		cleared   = rd_word & ~(word_t'(1) << slot_q[OFF_W-1:0]);
		frees_top = (top_q == $signed({1'b0, slot_q}));
		if (state_q == S_FREE) begin
			down_src = cleared & ((word_t'(1) << slot_q[OFF_W-1:0]) - word_t'(1));
		end else begin
			down_src = rd_word;
		end
		down_hit = |down_src;
		down_pos = highest_set(down_src);
	end

	// Memory port control. A read never targets the word written in the same cycle.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = widx_q;
		wr_en   = 1'b0;
		wr_addr = widx_q;
		wr_data = rd_word;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (req.operation == OP_ALLOC) begin
						rd_en   = !hint_full;
						rd_addr = hint_widx;
					end else begin
						rd_en   = in_range;
						rd_addr = in_slot[OFF_W +: WIDX_W];
					end
				end
			end
			S_ALLOC: begin
				if (alloc_hit) begin
					wr_en   = 1'b1;
					wr_data = rd_word | (word_t'(1) << alloc_pos);
				end else if (widx_q != LAST_WORD) begin
					rd_en   = 1'b1;
					rd_addr = widx_q + WIDX_W'(1);
				end
			end
			S_FREE: begin
				if (free_bit) begin
					wr_en   = 1'b1;
					wr_data = cleared;
					if (frees_top && !down_hit && widx_q != FIRST_WORD) begin
						rd_en   = 1'b1;
						rd_addr = widx_q - WIDX_W'(1);
					end
				end
			end
			S_DOWN: begin
				if (!down_hit && widx_q != FIRST_WORD) begin
					rd_en   = 1'b1;
					rd_addr = widx_q - WIDX_W'(1);
				end
			end
			S_EMIT: begin
			end
			default: begin
			end
		endcase
	end

	// Memory array with registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
			rd_ok_q   <= word_vld_q[rd_addr];
		end
	end

	// Mark a word valid on its first write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_vld_q <= '0;
		end else if (wr_en) begin
			word_vld_q[wr_addr] <= 1'b1;
		end
	end

	// Sequencer, allocator state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			slot_q       <= '0;
			widx_q       <= '0;
			off_q        <= '0;
			hint_q       <= '0;
			top_q        <= '1;
			live_q       <= '0;
			spawn_q      <= '0;
			res_status_q <= ST_OK;
			res_slot_q   <= '0;
			res_spawn_q  <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= ST_OK;
			out_slot_q   <= '0;
			out_spawn_q  <= '0;
			out_live_q   <= '0;
			out_top_q    <= '1;
		end else begin
			// drop the output beat once taken; in S_EMIT the load decides
			if (out_valid_q && rsp.ready && state_q != S_EMIT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						slot_q      <= in_slot;
						res_slot_q  <= '0;
						res_spawn_q <= '0;
						if (req.operation == OP_ALLOC) begin
							if (hint_full) begin
								res_status_q <= ST_FULL;
								state_q      <= S_EMIT;
							end else begin
								widx_q  <= hint_widx;
								off_q   <= hint_q[OFF_W-1:0];
								state_q <= S_ALLOC;
							end
						end else begin
							if (!in_range) begin
								res_status_q <= ST_BAD_FREE;
								state_q      <= S_EMIT;
							end else begin
								widx_q  <= in_slot[OFF_W +: WIDX_W];
								state_q <= S_FREE;
							end
						end
					end
				end
				S_ALLOC: begin
					if (alloc_hit) begin
						hint_q       <= CNT_W'(alloc_slot) + CNT_W'(1);
						if ($signed({1'b0, alloc_slot}) > top_q) begin
							top_q <= $signed({1'b0, alloc_slot});
						end
						live_q       <= live_q + CNT_W'(1);
						spawn_q      <= spawn_q + SPAWN_W'(1);
						res_spawn_q  <= spawn_q;
						res_slot_q   <= alloc_slot;
						res_status_q <= ST_OK;
						state_q      <= S_EMIT;
					end else if (widx_q == LAST_WORD) begin
						// scan ran off the end: saturate the hint
						hint_q       <= CNT_W'(SLOT_COUNT);
						res_status_q <= ST_FULL;
						state_q      <= S_EMIT;
					end else begin
						widx_q <= widx_q + WIDX_W'(1);
						off_q  <= '0;
					end
				end
				S_FREE: begin
					if (!free_bit) begin
						res_status_q <= ST_BAD_FREE;
						state_q      <= S_EMIT;
					end else begin
						res_status_q <= ST_OK;
						live_q       <= live_q - CNT_W'(1);
						if (hint_q > CNT_W'(slot_q)) begin
							hint_q <= CNT_W'(slot_q);
						end
						if (!frees_top) begin
							state_q <= S_EMIT;
						end else if (down_hit) begin
							top_q   <= $signed({1'b0, widx_q, down_pos});
							state_q <= S_EMIT;
						end else if (widx_q == FIRST_WORD) begin
							top_q   <= '1;
							state_q <= S_EMIT;
						end else begin
							widx_q  <= widx_q - WIDX_W'(1);
							state_q <= S_DOWN;
						end
					end
				end
				S_DOWN: begin
					if (down_hit) begin
						top_q   <= $signed({1'b0, widx_q, down_pos});
						state_q <= S_EMIT;
					end else if (widx_q == FIRST_WORD) begin
						top_q   <= '1;
						state_q <= S_EMIT;
					end else begin
						widx_q <= widx_q - WIDX_W'(1);
					end
				end
				S_EMIT: begin
					// hold until the output register is free
					if (!out_valid_q || rsp.ready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_slot_q   <= res_slot_q;
						out_spawn_q  <= res_spawn_q;
						out_live_q   <= live_q;
						out_top_q    <= top_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_status_q;
	assign rsp.granted_slot = SLOT_W'(out_slot_q);
	assign rsp.spawn_number = out_spawn_q;
	assign rsp.live_count   = LIVE_W'(out_live_q);
	assign rsp.highest_used = TOP_W'(out_top_q);

endmodule

### rtl/sfh_checker.sv
`include "assert_macros.svh"

module sfh_checker import sfh_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic [STATUS_W-1:0]     status,
	input logic [SLOT_W-1:0]       granted_slot,
	input logic [SPAWN_W-1:0]      spawn_number,
	input logic [LIVE_W-1:0]       live_count,
	input logic signed [TOP_W-1:0] highest_used
);

	// Stalled result beat holds.
	`SFH_ASSERT_NEXT(a_rsp_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(status) && $stable(granted_slot) && $stable(spawn_number) && $stable(live_count) && $stable(highest_used))

	// Failed requests carry no slot and no spawn number.
	`SFH_ASSERT_NOW(a_err_zero, clk, arst_n, out_valid && status != ST_OK, granted_slot == '0 && spawn_number == '0)

	// An empty table and a highest-used mark of -1 go together.
	`SFH_ASSERT_NOW(a_empty_top, clk, arst_n, out_valid, (live_count == '0) == (highest_used == '1))

	// Full is reported only when every slot is live.
	`SFH_ASSERT_NOW(a_full_live, clk, arst_n, out_valid && status == ST_FULL, live_count == LIVE_W'(SLOT_COUNT))

	// Status is always a known code.
	`SFH_ASSERT_NOW(a_status_code, clk, arst_n, out_valid, status == ST_OK || status == ST_FULL || status == ST_BAD_FREE)

endmodule

bind slot_allocator_first_free_hint_core sfh_checker u_sfh_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (rsp.valid),
	.out_ready    (rsp.ready),
	.status       (rsp.status),
	.granted_slot (rsp.granted_slot),
	.spawn_number (rsp.spawn_number),
	.live_count   (rsp.live_count),
	.highest_used (rsp.highest_used)
);

### tb/tb_slot_allocator_first_free_hint_core.sv
`timescale 1ns / 100ps

module tb_slot_allocator_first_free_hint_core;
	import sfh_pkg::*;

	// Give up once this many cycles pass with no beat on either channel.
	localparam int STALL_LIMIT = 2000;
	// Switch off all idling once this few requests are left to send.
	localparam int TAIL_ITEMS  = 150;

	// One request as queued for the driver.
	typedef struct packed {
		op_t               op;
		logic [SLOT_W-1:0] slot;
	} request_t;

	// One response as the allocator should produce it.
	typedef struct packed {
		status_t                  status;
		logic [SLOT_W-1:0]        granted;
		logic [SPAWN_W-1:0]       spawn;
		logic [LIVE_W-1:0]        live;
		logic signed [TOP_W-1:0]  top;
	} slot_result_t;

	// Table state: occupancy map, first-free hint, highest used slot,
	// live count and spawn counter.
	typedef struct packed {
		logic [SLOT_COUNT-1:0]    occ;
		logic [LIVE_W-1:0]        hint;
		logic signed [TOP_W-1:0]  top;
		logic [LIVE_W-1:0]        live;
		logic [SPAWN_W-1:0]       spawn;
	} table_state_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	sfh_req_if req_ch ();
	sfh_rsp_if rsp_ch ();

	slot_allocator_first_free_hint_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #2 clk = ~clk;

	request_t     pending_q[$];   // requests still to be sent
	slot_result_t response_q[$];  // responses owed by the allocator, oldest first
	table_state_t plan_table;     // table as the stimulus generator sees it
	table_state_t live_table;     // table as it stands after each accepted beat

	logic calm_tail;
	int   fail_count   = 0;
	int   cycle_count  = 0;
	int   stuck_cycles = 0;
	int   req_gap      = 0;
	int   rsp_stall    = 0;

	// Run statistics for the closing summary.
	int n_granted   = 0;
	int n_full      = 0;
	int n_freed     = 0;
	int n_bad_free  = 0;
	int peak_live   = 0;

	function automatic table_state_t empty_table();
		table_state_t s;
		s.occ   = '0;
		s.hint  = '0;
		s.top   = '1;
		s.live  = '0;
		s.spawn = '0;
		return s;
	endfunction

	// Apply one request to a table and return the table after it; the
	// response the allocator owes comes back through r.
	function automatic table_state_t step_table(input table_state_t s, input op_t op,
			input logic [SLOT_W-1:0] slot, output slot_result_t r);
		int h;
		int t;
		r = '{status: ST_OK, granted: '0, spawn: '0, live: '0, top: '0};
		if (op == OP_ALLOC) begin
			// Scan upward from the hint, saturating it at the table size.
			h = int'(s.hint);
			if (h > SLOT_COUNT)
				h = SLOT_COUNT;
			while (h < SLOT_COUNT && s.occ[h])
				h++;
			if (h >= SLOT_COUNT) begin
				s.hint   = LIVE_W'(SLOT_COUNT);
				r.status = ST_FULL;
			end else begin
				s.occ[h]  = 1'b1;
				s.hint    = LIVE_W'(h + 1);
				r.granted = h[SLOT_W-1:0];
				r.spawn   = s.spawn;
				s.spawn   = s.spawn + SPAWN_W'(1);
				if (h > int'(s.top))
					s.top = TOP_W'(h);
				s.live = s.live + LIVE_W'(1);
			end
		end else if (int'(slot) >= SLOT_COUNT || !s.occ[slot]) begin
			// Freeing an empty or out-of-range slot changes nothing.
			r.status = ST_BAD_FREE;
		end else begin
			s.occ[slot] = 1'b0;
			if (s.live != 0)
				s.live = s.live - LIVE_W'(1);
			if (s.hint > slot)
				s.hint = LIVE_W'(slot);
			// Freed the top slot: walk down to the next occupied one, or -1.
			if (int'(slot) == int'(s.top)) begin
				t = int'(s.top);
				do
					t--;
				while (t >= 0 && !s.occ[t]);
				s.top = TOP_W'(t);
			end
		end
		r.live = s.live;
		r.top  = s.top;
		return s;
	endfunction

	// Queue a request and advance the generator's copy of the table.
	task automatic queue_request(input op_t op, input logic [SLOT_W-1:0] slot);
		slot_result_t ignored;
		pending_q.push_back('{op: op, slot: slot});
		plan_table = step_table(plan_table, op, slot, ignored);
	endtask

	// Pick an occupied slot at random; on an empty table any slot will do.
	function automatic logic [SLOT_W-1:0] any_live_slot();
		int start;
		int idx;
		start = $urandom_range(0, SLOT_COUNT - 1);
		for (int i = 0; i < SLOT_COUNT; i++) begin
			idx = (start + i) % SLOT_COUNT;
			if (plan_table.occ[idx])
				return idx[SLOT_W-1:0];
		end
		return start[SLOT_W-1:0];
	endfunction

	function automatic logic [SLOT_W-1:0] random_slot();
		return SLOT_W'($urandom_range(0, SLOT_COUNT - 1));
	endfunction

	// Idling comes in moods that rotate with the cycle count: none, heavy, light.
	function automatic bit start_idle_burst();
		case ((cycle_count >> 8) % 3)
			0:       return 1'b0;
			1:       return $urandom_range(0, 3) == 0;
			default: return $urandom_range(0, 11) == 0;
		endcase
	endfunction

	function automatic void compare_field(input string name, input logic signed [63:0] want,
			input logic signed [63:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	// Request driver: present the next pending request, with random gaps.
	always @(posedge clk or negedge arst_n) begin
		request_t     nxt;
		slot_result_t res;
		if (!arst_n) begin
			req_ch.valid      <= 1'b0;
			req_ch.operation  <= OP_ALLOC;
			req_ch.slot_index <= '0;
			calm_tail         <= 1'b0;
			req_gap = 0;
			live_table = empty_table();
		end else begin
			// Accepted beat: advance the table and record what is owed.
			if (req_ch.valid && req_ch.ready) begin
				live_table = step_table(live_table, op_t'(req_ch.operation),
					req_ch.slot_index, res);
				response_q.push_back(res);
				case (res.status)
					ST_FULL:     n_full++;
					ST_BAD_FREE: n_bad_free++;
					default: begin
						if (op_t'(req_ch.operation) == OP_ALLOC)
							n_granted++;
						else
							n_freed++;
					end
				endcase
				if (int'(res.live) > peak_live)
					peak_live = int'(res.live);
			end
			calm_tail <= pending_q.size() <= TAIL_ITEMS;
			// Hold the current beat until it is taken.
			if (!req_ch.valid || req_ch.ready) begin
				if (req_gap > 0) begin
					req_gap--;
					req_ch.valid <= 1'b0;
				end else if (!calm_tail && pending_q.size() > 0 && start_idle_burst()) begin
					req_gap = $urandom_range(1, 13) - 1;
					req_ch.valid <= 1'b0;
				end else if (pending_q.size() > 0) begin
					nxt = pending_q.pop_front();
					req_ch.valid      <= 1'b1;
					req_ch.operation  <= nxt.op;
					req_ch.slot_index <= nxt.slot;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Response monitor: check each beat against the oldest owed response and
	// throttle ready in random bursts.
	always @(posedge clk or negedge arst_n) begin
		slot_result_t want;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			rsp_stall = 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (response_q.size() == 0) begin
					$error("response beat with no request outstanding: status %0d slot %0d",
						rsp_ch.status, rsp_ch.granted_slot);
					fail_count++;
				end else begin
					want = response_q.pop_front();
					compare_field("status", want.status, rsp_ch.status);
					compare_field("granted_slot", want.granted, rsp_ch.granted_slot);
					compare_field("spawn_number", want.spawn, rsp_ch.spawn_number);
					compare_field("live_count", want.live, rsp_ch.live_count);
					compare_field("highest_used", want.top, rsp_ch.highest_used);
				end
			end
			if (rsp_stall > 0) begin
				rsp_stall--;
				rsp_ch.ready <= 1'b0;
			end else if (!calm_tail && start_idle_burst()) begin
				rsp_stall = $urandom_range(1, 13) - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Watchdog: drop the run if neither channel moves for too long.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
				stuck_cycles <= 0;
			end else if (stuck_cycles >= STALL_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end else begin
				stuck_cycles <= stuck_cycles + 1;
			end
		end
	end

	initial begin
		int roll;
		plan_table = empty_table();

		// Directed opening: first grants, hint pull-back, frees of empty slots
		// (including the all-ones index), top walk-down and the empty table.
		queue_request(OP_ALLOC, '0);
		queue_request(OP_ALLOC, '1);
		queue_request(OP_ALLOC, '0);
		queue_request(OP_FREE, SLOT_W'(1));       // hint falls back to 1
		queue_request(OP_FREE, SLOT_W'(1));       // already empty
		queue_request(OP_FREE, '1);               // top index, never taken
		queue_request(OP_ALLOC, '0);              // refills slot 1
		queue_request(OP_FREE, SLOT_W'(2));       // top slot: mark walks to 1
		queue_request(OP_FREE, SLOT_W'(0));
		queue_request(OP_FREE, SLOT_W'(1));       // last slot: mark goes to -1
		queue_request(OP_FREE, '0);               // free on an empty table
		queue_request(OP_FREE, SLOT_W'(10'h2AA));
		queue_request(OP_ALLOC, '1);
		queue_request(OP_ALLOC, '0);
		queue_request(OP_FREE, SLOT_W'(0));
		queue_request(OP_ALLOC, '0);              // hint pulled back to 0
		queue_request(OP_FREE, SLOT_W'(10'h155));

		// Mixed traffic on a sparse table.
		repeat (110) begin
			roll = $urandom_range(0, 99);
			if (roll < 55)
				queue_request(OP_ALLOC, random_slot());
			else if (roll < 85)
				queue_request(OP_FREE, any_live_slot());
			else
				queue_request(OP_FREE, random_slot());
		end

		// Fill the table to the brim with the odd free mixed in.
		while (int'(plan_table.live) < SLOT_COUNT) begin
			roll = $urandom_range(0, 99);
			if (roll < 94)
				queue_request(OP_ALLOC, random_slot());
			else if (roll < 97)
				queue_request(OP_FREE, any_live_slot());
			else
				queue_request(OP_FREE, random_slot());
		end

		// Full table: the hint saturates, then lower frees drag it back.
		repeat (3)
			queue_request(OP_ALLOC, random_slot());
		repeat (8) begin
			queue_request(OP_FREE, any_live_slot());
			queue_request(OP_ALLOC, random_slot());
			queue_request(OP_ALLOC, random_slot());
		end
		queue_request(OP_FREE, '1);
		queue_request(OP_FREE, SLOT_W'(SLOT_COUNT - 2));
		queue_request(OP_ALLOC, random_slot());
		queue_request(OP_ALLOC, random_slot());

		// Drain: frees dominate, often of the top slot so the mark walks down.
		repeat (170) begin
			roll = $urandom_range(0, 99);
			if (roll < 50)
				queue_request(OP_FREE, any_live_slot());
			else if (roll < 70)
				queue_request(OP_FREE, plan_table.top[SLOT_W-1:0]);
			else if (roll < 85)
				queue_request(OP_ALLOC, random_slot());
			else
				queue_request(OP_FREE, random_slot());
		end

		// Hold reset and release it away from the rising edge.
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait until every request is sent and every response is in.
		while (pending_q.size() != 0 || req_ch.valid || response_q.size() != 0)
			@(posedge clk);
		// Allow a stray extra beat time to show up.
		repeat (40) @(posedge clk);

		$display("Covered %0d grants, %0d full replies, %0d frees, %0d invalid frees.",
			n_granted, n_full, n_freed, n_bad_free);
		$display("Peak live count %0d of %0d slots; %0d mismatches.",
			peak_live, SLOT_COUNT, fail_count);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
